### hdl/oais_pkg.sv
// Package for the ordered array block: operation and status codes,
// cell control types. No dependencies.
`timescale 1ns / 1ps

package oais_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    localparam int ENTRY_W = 32;
    localparam int POS_W   = 7;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LOWER,
        SEL_UPPER
    } t_cell_sel;

    typedef struct packed {
        t_cell_sel sel;
        logic      cmp_en;
    } t_cell_ctl;

endpackage

### hdl/ordered_array_insert_search_delete.sv
// Ordered array of signed 32-bit entries with insert, search and delete.
// A request is taken only in idle and passes through the compare and shift
// states, so a new one is not taken until the last is through; a result left
// waiting on the output holds the next request in its shift state until taken.
// Reset (synchronous, active low) clears the count and control; entries are
// left as they are and only read once written.
`timescale 1ns / 1ps

module ordered_array_insert_search_delete
    import oais_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op [1:0], value [33:2], position [40:34], zero [47:41]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [1:0], found_index [8:2], entry_count [15:9]
    output logic [15:0] m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state                    r_state;
    logic [1:0]                r_op;
    logic signed [ENTRY_W-1:0] r_value;
    logic [POS_W-1:0]          r_pos;
    logic [CW-1:0]             r_count;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [POS_W-1:0]          r_idx;
    logic [POS_W-1:0]          r_cnt;

    t_cell_ctl                 ctl     [DEPTH];
    logic signed [ENTRY_W-1:0] entry   [DEPTH];
    logic [DEPTH-1:0]          match;
    logic [DEPTH-1:0]          hit;
    logic [DEPTH-1:0]          first;
    logic [DEPTH-1:0]          below;
    logic [CW-1:0]             hit_idx;
    logic [PW-1:0]             pos_x;
    logic [PW-1:0]             cnt_x;
    logic                      exec_go;
    logic                      ins_full;
    logic                      ins_bad;
    logic                      ins_ok;
    logic                      del_ok;
    logic [1:0]                n_status;
    logic [CW-1:0]             n_idx;
    logic [CW-1:0]             n_count;

    assign s_axis_tready = (r_state == S_IDLE);
    assign exec_go       = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign pos_x    = PW'(r_pos);
    assign cnt_x    = PW'(r_count);
    assign ins_full = (cnt_x >= PW'(DEPTH));
    assign ins_bad  = (r_pos == '0) || (pos_x > cnt_x + PW'(1));

    // Only cells below the count take part in the match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = match[i] && (PW'(i) < cnt_x);
        end
    end

    // Isolate the first match and the cells below it
    assign first = hit & (~hit + DEPTH'(1));
    assign below = first - DEPTH'(1);

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                hit_idx = hit_idx | CW'(i + 1);
            end
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_idx    = '0;
        n_count  = r_count;
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (ins_full) begin
                    n_status = ST_FULL;
                end else if (ins_bad) begin
                    n_status = ST_BAD_POS;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_SEARCH: begin
                n_idx = hit_idx;
                if (hit == '0) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_DELETE: begin
                n_idx = hit_idx;
                if (hit == '0) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    del_ok  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Per-cell control: compare enable in the compare state; load, shift up from below, shift down from above
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ctl[i].cmp_en = (r_state == S_CMP);
            ctl[i].sel    = SEL_HOLD;
            if (exec_go && ins_ok) begin
                if (PW'(i + 1) == pos_x) begin
                    ctl[i].sel = SEL_LOAD;
                end else if (PW'(i) >= pos_x && PW'(i) <= cnt_x) begin
                    ctl[i].sel = SEL_LOWER;
                end
            end else if (exec_go && del_ok) begin
                if (!below[i] && (PW'(i + 1) < cnt_x)) begin
                    ctl[i].sel = SEL_UPPER;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        oais_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_value (r_value),
            .i_lower (entry[(g == 0) ? 0 : g - 1]),
            .i_upper (entry[(g == DEPTH - 1) ? g : g + 1]),
            .o_entry (entry[g]),
            .o_match (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op    <= s_axis_tdata[1:0];
            r_value <= s_axis_tdata[33:2];
            r_pos   <= s_axis_tdata[40:34];
        end
        if (exec_go) begin
            r_status <= n_status;
            r_idx    <= POS_W'(n_idx);
            r_cnt    <= POS_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_cnt, r_idx, r_status};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_count) <= PW'(DEPTH))
        else $error("entry count above depth");

    a_idx_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[8:2] != '0)) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("found index with failing status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL))
        |-> (m_axis_tdata[15:9] == POS_W'(DEPTH)))
        else $error("full status below depth");

    a_one_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> ((r_count == $past(r_count))
                     || (r_count == $past(r_count) + CW'(1))
                     || (r_count == $past(r_count) - CW'(1))))
        else $error("count moved by more than one");
`endif

endmodule

### hdl/oais_cell.sv
// One storage cell of the ordered array row: holds one entry, compares it
// with the broadcast key and takes data from either neighbour. Uses oais_pkg.
`timescale 1ns / 1ps

module oais_cell
    import oais_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [ENTRY_W-1:0] i_value,
    input  logic signed [ENTRY_W-1:0] i_lower,
    input  logic signed [ENTRY_W-1:0] i_upper,
    output logic signed [ENTRY_W-1:0] o_entry,
    output logic                      o_match
);

    logic signed [ENTRY_W-1:0] r_entry;
    logic                      r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctl.sel)
            SEL_LOAD:  r_entry <= i_value;
            SEL_LOWER: r_entry <= i_lower;
            SEL_UPPER: r_entry <= i_upper;
            default:   r_entry <= r_entry;
        endcase
        if (i_ctl.cmp_en) begin
            r_match <= (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule
